/* src/centroid_track_id_assigner_unit_macros.svh */
// Assertion macros for the centroid track id assigner.
`ifndef CENTROID_TRACK_ID_ASSIGNER_UNIT_MACROS_SVH
`define CENTROID_TRACK_ID_ASSIGNER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication under an active-low reset.
`define CTIA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication under an active-low reset.
`define CTIA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CTIA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CTIA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/ctia_pkg.sv */
// Shared constants for the centroid track id assigner.
package ctia_pkg;

    localparam int KIND_W = 2;
    localparam logic [KIND_W-1:0] KIND_DETECT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EOF    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam int ID_W = 32;
    localparam logic [ID_W-1:0] ID_FIRST = 32'd1;

    localparam int RADIUS_W = 8;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd20;

endpackage

/* src/ctia_fifo.sv */
// Small synchronous queue used between the front, the back and the result port.
module ctia_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             is_full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             is_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);
    assign do_wr    = wr_en && !is_full;
    assign do_rd    = rd_en && !is_empty;
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* src/ctia_front.sv */
// Front stage: accepts requests, computes centres and drops unused kinds.
module ctia_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    output logic                                  full,
    input  logic [ctia_pkg::KIND_W-1:0]           kind,
    input  logic [COORD_BITS-1:0]                 rect_left,
    input  logic [COORD_BITS-1:0]                 rect_top,
    input  logic [COORD_BITS-1:0]                 rect_width,
    input  logic [COORD_BITS-1:0]                 rect_height,
    output logic                                  q_push,
    output logic [ctia_pkg::KIND_W+2*COORD_BITS+1:0] q_data,
    input  logic                                  q_full
);

    localparam int CW    = COORD_BITS + 1;
    localparam int CMD_W = ctia_pkg::KIND_W + 2 * CW;

    logic             stage_valid_reg, stage_valid_next;
    logic [CMD_W-1:0] stage_data_reg;
    logic             accept, keep;
    logic [CW-1:0]    cx, cy;

    assign full   = stage_valid_reg && q_full;
    assign accept = push && !full;
    assign keep   = (kind == ctia_pkg::KIND_DETECT) || (kind == ctia_pkg::KIND_EOF)
                 || (kind == ctia_pkg::KIND_CLEAR);
    assign cx     = {1'b0, rect_left} + {2'b00, rect_width[COORD_BITS-1:1]};
    assign cy     = {1'b0, rect_top} + {2'b00, rect_height[COORD_BITS-1:1]};
    assign q_push = stage_valid_reg;
    assign q_data = stage_data_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg && q_full;
        if (accept && keep)
        begin
            stage_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            stage_data_reg <= {kind, cx, cy};
        end
    end

endmodule

/* src/ctia_back.sv */
// Back stage: scans the previous-frame table, assigns ids and keeps the track tables.
module ctia_back #(
    parameter int MAX_OBJECTS = 64,
    parameter int COORD_BITS  = 12
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic [ctia_pkg::RADIUS_W-1:0]                    radius,
    input  logic                                             cmd_empty,
    input  logic [ctia_pkg::KIND_W+2*COORD_BITS+1:0]         cmd_data,
    output logic                                             cmd_pop,
    input  logic                                             res_full,
    output logic                                             res_push,
    output logic [ctia_pkg::ID_W+2*COORD_BITS+3:0]           res_data
);

    localparam int CW        = COORD_BITS + 1;
    localparam int SQ_W      = 2 * CW;
    localparam int SUM_W     = SQ_W + 1;
    localparam int R2_W      = 2 * ctia_pkg::RADIUS_W;
    localparam int IDX_W     = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CNT_W     = $clog2(MAX_OBJECTS + 1);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int MEM_DEPTH = 2 << IDX_W;
    localparam int ENTRY_W   = ctia_pkg::ID_W + 2 * CW;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                    state_reg, state_next;
    logic                      bank_reg, bank_next;
    logic [CNT_W-1:0]          prev_cnt_reg, prev_cnt_next;
    logic [CNT_W-1:0]          cur_cnt_reg, cur_cnt_next;
    logic [CNT_W-1:0]          issue_reg, issue_next;
    logic [ctia_pkg::ID_W-1:0] next_id_reg, next_id_next;
    logic [ctia_pkg::ID_W-1:0] id_inc;
    logic [CW-1:0]             cx_reg, cx_next, cy_reg, cy_next;
    logic                      match_reg, match_next;
    logic [ctia_pkg::ID_W-1:0] match_id_reg, match_id_next;
    logic                      p1_valid_reg, p1_valid_next;
    logic                      p2_valid_reg, p2_valid_next;
    logic [R2_W-1:0]           r2_reg;
    logic [SQ_W-1:0]           sqx_reg, sqy_reg;
    logic [ctia_pkg::ID_W-1:0] p2_id_reg;

    logic [ENTRY_W-1:0]        mem [MEM_DEPTH];
    logic [ENTRY_W-1:0]        rd_data_reg;
    logic                      rd_en, mem_we;
    logic [ADDR_W-1:0]         rd_addr, wr_addr;
    logic [ENTRY_W-1:0]        wr_data;

    logic [ctia_pkg::KIND_W-1:0] cmd_kind;
    logic [CW-1:0]             cmd_cx, cmd_cy;
    logic [ctia_pkg::ID_W-1:0] ent_id;
    logic [CW-1:0]             ent_cx, ent_cy, dx, dy;
    logic [SUM_W-1:0]          dist2;
    logic                      hit, has_room;
    logic [ctia_pkg::ID_W-1:0] out_id;

    assign {cmd_kind, cmd_cx, cmd_cy} = cmd_data;
    assign {ent_id, ent_cx, ent_cy}   = rd_data_reg;

    assign dx    = (cx_reg >= ent_cx) ? cx_reg - ent_cx : ent_cx - cx_reg;
    assign dy    = (cy_reg >= ent_cy) ? cy_reg - ent_cy : ent_cy - cy_reg;
    assign dist2 = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign hit   = (state_reg == ST_SCAN) && p2_valid_reg
                && (dist2 < SUM_W'(r2_reg));

    assign rd_en   = (state_reg == ST_SCAN) && (issue_reg < prev_cnt_reg) && !hit;
    assign rd_addr = {~bank_reg, issue_reg[IDX_W-1:0]};

    assign has_room = (cur_cnt_reg < CNT_W'(MAX_OBJECTS));
    assign out_id   = match_reg ? match_id_reg : next_id_reg;
    assign id_inc   = next_id_reg + 1'b1;
    assign wr_addr  = {bank_reg, cur_cnt_reg[IDX_W-1:0]};
    assign wr_data  = {out_id, cx_reg, cy_reg};
    assign mem_we   = (state_reg == ST_DONE) && !res_full && has_room;

    assign cmd_pop  = (state_reg == ST_IDLE) && !cmd_empty;
    assign res_push = (state_reg == ST_DONE) && !res_full;
    assign res_data = {out_id, cx_reg, cy_reg, match_reg, !has_room};

    always_comb
    begin
        state_next    = state_reg;
        bank_next     = bank_reg;
        prev_cnt_next = prev_cnt_reg;
        cur_cnt_next  = cur_cnt_reg;
        issue_next    = issue_reg;
        next_id_next  = next_id_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        match_next    = match_reg;
        match_id_next = match_id_reg;
        p1_valid_next = rd_en;
        p2_valid_next = (state_reg == ST_SCAN) && p1_valid_reg && !hit;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    unique case (cmd_kind)
                        ctia_pkg::KIND_DETECT:
                        begin
                            cx_next    = cmd_cx;
                            cy_next    = cmd_cy;
                            issue_next = '0;
                            match_next = 1'b0;
                            state_next = ST_SCAN;
                        end
                        ctia_pkg::KIND_EOF:
                        begin
                            bank_next     = ~bank_reg;
                            prev_cnt_next = cur_cnt_reg;
                            cur_cnt_next  = '0;
                        end
                        ctia_pkg::KIND_CLEAR:
                        begin
                            prev_cnt_next = '0;
                            cur_cnt_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                if (hit)
                begin
                    match_next    = 1'b1;
                    match_id_next = p2_id_reg;
                    state_next    = ST_DONE;
                end
                else if (!rd_en && !p1_valid_reg && !p2_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!res_full)
                begin
                    if (!match_reg)
                    begin
                        next_id_next = (id_inc == '0) ? ctia_pkg::ID_FIRST : id_inc;
                    end
                    if (has_room)
                    begin
                        cur_cnt_next = cur_cnt_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bank_reg     <= 1'b0;
            prev_cnt_reg <= '0;
            cur_cnt_reg  <= '0;
            next_id_reg  <= ctia_pkg::ID_FIRST;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            match_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bank_reg     <= bank_next;
            prev_cnt_reg <= prev_cnt_next;
            cur_cnt_reg  <= cur_cnt_next;
            next_id_reg  <= next_id_next;
            p1_valid_reg <= p1_valid_next;
            p2_valid_reg <= p2_valid_next;
            match_reg    <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_reg    <= issue_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        match_id_reg <= match_id_next;
        r2_reg       <= R2_W'(radius) * R2_W'(radius);
        sqx_reg      <= SQ_W'(dx) * SQ_W'(dx);
        sqy_reg      <= SQ_W'(dy) * SQ_W'(dy);
        p2_id_reg    <= ent_id;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

/* src/centroid_track_id_assigner_unit.sv */
// Top level of the centroid track id assigner.
// A detection request is taken by the back stage in its idle state, then scans the
// entries kept from the previous frame in the track memory one entry per cycle,
// stopping early on a match, then hands over its result in the done state;
// end-of-frame and clear requests are handled in the idle state. The front stage
// computes the centre and queues requests, so it keeps accepting while a scan runs
// until both its input register and the four-entry request queue are occupied.
// Results wait in a two-entry queue. The match radius may be written only while no
// request is outstanding. The track memory is not cleared after reset; only entries
// below the valid counts are ever read.
`include "centroid_track_id_assigner_unit_macros.svh"
module centroid_track_id_assigner_unit #(
    parameter int MAX_OBJECTS = 64,
    parameter int COORD_BITS  = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [ctia_pkg::KIND_W-1:0]     kind,
    input  logic [COORD_BITS-1:0]           rect_left,
    input  logic [COORD_BITS-1:0]           rect_top,
    input  logic [COORD_BITS-1:0]           rect_width,
    input  logic [COORD_BITS-1:0]           rect_height,
    output logic                            empty,
    input  logic                            pop,
    output logic [ctia_pkg::ID_W-1:0]       object_id,
    output logic [COORD_BITS:0]             center_x,
    output logic [COORD_BITS:0]             center_y,
    output logic                            matched,
    output logic                            table_full,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ctia_pkg::RADIUS_W-1:0]   cfg_data
);

    localparam int CW    = COORD_BITS + 1;
    localparam int CMD_W = ctia_pkg::KIND_W + 2 * CW;
    localparam int RES_W = ctia_pkg::ID_W + 2 * CW + 2;

    logic [ctia_pkg::RADIUS_W-1:0] radius_reg;
    logic                          cmd_push, cmd_full, cmd_pop, cmd_empty;
    logic [CMD_W-1:0]              cmd_in, cmd_out;
    logic                          res_push, res_full;
    logic [RES_W-1:0]              res_in, res_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= ctia_pkg::RADIUS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            radius_reg <= cfg_data;
        end
    end

    ctia_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .rect_left   (rect_left),
        .rect_top    (rect_top),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .q_push      (cmd_push),
        .q_data      (cmd_in),
        .q_full      (cmd_full)
    );

    ctia_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (4)
    ) u_cmd_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cmd_push),
        .wr_data  (cmd_in),
        .is_full  (cmd_full),
        .rd_en    (cmd_pop),
        .rd_data  (cmd_out),
        .is_empty (cmd_empty)
    );

    ctia_back #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .COORD_BITS  (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .radius    (radius_reg),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    ctia_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (res_push),
        .wr_data  (res_in),
        .is_full  (res_full),
        .rd_en    (pop),
        .rd_data  (res_out),
        .is_empty (empty)
    );

    assign {object_id, center_x, center_y, matched, table_full} = res_out;

    `CTIA_ASSERT_IMP(a_id_nonzero, clk, rst_n, !empty, object_id != '0, "zero object id")
    `CTIA_ASSERT_IMP(a_res_no_overflow, clk, rst_n, res_push, !res_full, "result overflow")
    `CTIA_ASSERT_IMP(a_cmd_no_overflow, clk, rst_n, cmd_push && cmd_full, full,
        "request queue overflow")
    `CTIA_ASSERT_NXT(a_res_visible, clk, rst_n, res_push, !empty, "result lost")

endmodule
